### rtl/nearest_node_and_kill_query_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest node and kill query unit
// Each macro is one labeled concurrent assertion clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NODE_AND_KILL_QUERY_UNIT_DEFINES_SVH
`define NEAREST_NODE_AND_KILL_QUERY_UNIT_DEFINES_SVH

// same-cycle implication
`define NNKQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nnkq: assertion failed");

// next-cycle implication
`define NNKQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nnkq: assertion failed");

`endif

### rtl/nnkq_pkg.sv
// ----------------------------------------------------------------------------
// nnkq_pkg
// Item types, codes and fixed widths of the nearest node and kill query unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nnkq_pkg;

  localparam int FIELD_W   = 16;
  localparam int RAD_W     = 16;
  localparam int IDX_OUT_W = 11;
  localparam int DSQ_W     = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTRACT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL    = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [FIELD_W-1:0] px;
    logic signed [FIELD_W-1:0] py;
    logic                      restart;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] nearest_index;
    logic                 killed;
  } out_item_t;

  // one distance result per node; far means the distance exceeds any radius
  typedef struct packed {
    logic             valid;
    logic             far;
    logic [DSQ_W-1:0] d_sq;
  } dist_res_t;

endpackage

`default_nettype wire

### rtl/nearest_node_and_kill_query_unit.sv
// ----------------------------------------------------------------------------
// nearest_node_and_kill_query_unit
// Stores node points and answers nearest-node / kill queries by a scan over
// the node memory through a pipelined squared distance unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | nnkq_pkg::in_item_t
//  out     | output    | out_valid_o/out_ready_i | nnkq_pkg::out_item_t
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
//  A load item is taken in the idle state. A query item scans one node per
//  cycle through the memory read port, drains the read and distance pipeline
//  and then registers the result; with an empty set the scan is skipped.
//  Loads are taken while a result waits; a query finishing while the previous
//  result is still held waits in the final state for out_ready_i.
//  Reset empties the node set and clears the radii; no memory clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_node_and_kill_query_unit_defines.svh"

module nearest_node_and_kill_query_unit #(
  parameter int MAX_NODES  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  nnkq_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output nnkq_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [nnkq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [nnkq_pkg::RAD_W-1:0]         cfg_wdata_i
);

  localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);
  localparam int DSQ_W = nnkq_pkg::DSQ_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        issue_q, issue_d, issue_nxt;
  logic                    rd_valid_q, rd_valid_d;
  logic [CNT_W-1:0]        rd_idx_q, rd_idx_d;
  logic signed [COORD_BITS-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [DSQ_W-1:0]        best_sq_q, best_sq_d, kill_sq_q, kill_sq_d;
  logic [CNT_W-1:0]        best_idx_q, best_idx_d;
  logic                    killed_q, killed_d;
  logic                    out_valid_q, out_valid_d;
  nnkq_pkg::out_item_t     out_item_q, out_item_d;
  logic [nnkq_pkg::RAD_W-1:0] attract_q, kill_q;

  logic                    in_acc, store_ok, mem_we;
  logic                    query_acc, scanning;
  logic [CNT_W-1:0]        base_cnt;
  logic [ADDR_W-1:0]       waddr;
  logic [31:0]             px_ext, py_ext, ar_sq, kr_sq, best_idx_wide;
  logic signed [COORD_BITS-1:0] px_c, py_c, nx, ny;
  nnkq_pkg::dist_res_t     dist_res;
  logic [CNT_W-1:0]        dist_idx;
  logic                    dist_busy;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign query_acc  = in_acc && (in_item_i.op == nnkq_pkg::OP_QUERY) && (count_q != '0);
  assign scanning   = (state_q == ST_SCAN) || (state_q == ST_DRAIN);

  assign px_ext = {{(32 - nnkq_pkg::FIELD_W){in_item_i.px[nnkq_pkg::FIELD_W-1]}},
                   in_item_i.px};
  assign py_ext = {{(32 - nnkq_pkg::FIELD_W){in_item_i.py[nnkq_pkg::FIELD_W-1]}},
                   in_item_i.py};
  assign px_c   = px_ext[COORD_BITS-1:0];
  assign py_c   = py_ext[COORD_BITS-1:0];

  assign base_cnt  = in_item_i.restart ? '0 : count_q;
  assign store_ok  = in_item_i.restart || (count_q < MAX_CNT);
  assign waddr     = base_cnt[ADDR_W-1:0];
  assign issue_nxt = issue_q + 1'b1;

  assign ar_sq = {16'b0, attract_q} * {16'b0, attract_q};
  assign kr_sq = {16'b0, kill_q} * {16'b0, kill_q};
  assign best_idx_wide = 32'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attract_q <= '0;
      kill_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nnkq_pkg::CFG_ATTRACT: attract_q <= cfg_wdata_i;
        nnkq_pkg::CFG_KILL:    kill_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  nnkq_node_store #(
    .DEPTH      (MAX_NODES),
    .ADDR_W     (ADDR_W),
    .COORD_BITS (COORD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wx_i    (px_c),
    .wy_i    (py_c),
    .raddr_i (issue_q[ADDR_W-1:0]),
    .rx_o    (nx),
    .ry_o    (ny)
  );

  nnkq_dist_unit #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (CNT_W)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rd_valid_q),
    .in_idx_i   (rd_idx_q),
    .qx_i       (qx_q),
    .qy_i       (qy_q),
    .nx_i       (nx),
    .ny_i       (ny),
    .res_o      (dist_res),
    .res_idx_o  (dist_idx),
    .busy_o     (dist_busy)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    rd_valid_d  = 1'b0;
    rd_idx_d    = rd_idx_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    best_sq_d   = best_sq_q;
    kill_sq_d   = kill_sq_q;
    best_idx_d  = best_idx_q;
    killed_d    = killed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;

    // lowest index wins on ties: strict compare in ascending order
    if (dist_res.valid && !dist_res.far) begin
      if (dist_res.d_sq < best_sq_q) begin
        best_sq_d  = dist_res.d_sq;
        best_idx_d = dist_idx;
      end
      if (dist_res.d_sq <= kill_sq_q) begin
        killed_d = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.op == nnkq_pkg::OP_LOAD) begin
            if (store_ok) begin
              mem_we  = 1'b1;
              count_d = base_cnt + 1'b1;
            end
          end else begin
            qx_d       = px_c;
            qy_d       = py_c;
            best_sq_d  = {1'b0, ar_sq};
            kill_sq_d  = {1'b0, kr_sq};
            best_idx_d = '0;
            killed_d   = 1'b0;
            issue_d    = '0;
            state_d    = (count_q == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_valid_d = 1'b1;
        rd_idx_d   = issue_nxt;
        issue_d    = issue_nxt;
        if (issue_nxt == count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !dist_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_item_d.nearest_index = best_idx_wide[nnkq_pkg::IDX_OUT_W-1:0];
          out_item_d.killed        = killed_q;
          state_d                  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      rd_idx_q    <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      best_sq_q   <= '0;
      kill_sq_q   <= '0;
      best_idx_q  <= '0;
      killed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      rd_valid_q  <= rd_valid_d;
      rd_idx_q    <= rd_idx_d;
      qx_q        <= qx_d;
      qy_q        <= qy_d;
      best_sq_q   <= best_sq_d;
      kill_sq_q   <= kill_sq_d;
      best_idx_q  <= best_idx_d;
      killed_q    <= killed_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `NNKQ_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= MAX_CNT)
  `NNKQ_ASSERT_IMP(a_res_in_scan, clk_i, rst_ni, dist_res.valid, scanning)
  `NNKQ_ASSERT_IMP(a_finish_idx, clk_i, rst_ni, state_q == ST_FINISH, best_idx_q <= count_q)
  `NNKQ_ASSERT_NXT(a_query_scan, clk_i, rst_ni, query_acc, state_q == ST_SCAN)

endmodule

`default_nettype wire

### rtl/nnkq_node_store.sv
// ----------------------------------------------------------------------------
// nnkq_node_store
// Node point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nnkq_node_store #(
  parameter int DEPTH      = 1024,
  parameter int ADDR_W     = 10,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [ADDR_W-1:0]            waddr_i,
  input  logic signed [COORD_BITS-1:0] wx_i,
  input  logic signed [COORD_BITS-1:0] wy_i,
  input  logic [ADDR_W-1:0]            raddr_i,
  output logic signed [COORD_BITS-1:0] rx_o,
  output logic signed [COORD_BITS-1:0] ry_o
);

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wx_i, wy_i};
    end
    rdata_q <= mem[raddr_i];
  end

  assign rx_o = rdata_q[2*COORD_BITS-1:COORD_BITS];
  assign ry_o = rdata_q[COORD_BITS-1:0];

endmodule

`default_nettype wire

### rtl/nnkq_dist_unit.sv
// ----------------------------------------------------------------------------
// nnkq_dist_unit
// Three-stage squared distance pipeline: abs difference, square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nnkq_dist_unit #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [IDX_W-1:0]             in_idx_i,
  input  logic signed [COORD_BITS-1:0] qx_i,
  input  logic signed [COORD_BITS-1:0] qy_i,
  input  logic signed [COORD_BITS-1:0] nx_i,
  input  logic signed [COORD_BITS-1:0] ny_i,
  output nnkq_pkg::dist_res_t          res_o,
  output logic [IDX_W-1:0]             res_idx_o,
  output logic                         busy_o
);

  logic [COORD_BITS:0]   dx, dy, adx, ady;
  logic [31:0]           ax_w, ay_w;

  logic                  s1_valid_q, s2_valid_q, s3_valid_q;
  logic                  s1_far_q, s2_far_q, s3_far_q;
  logic [IDX_W-1:0]      s1_idx_q, s2_idx_q, s3_idx_q;
  logic [15:0]           s1_ax_q, s1_ay_q;
  logic [31:0]           s2_sqx_q, s2_sqy_q;
  logic [nnkq_pkg::DSQ_W-1:0] s3_dsq_q;

  assign dx   = {qx_i[COORD_BITS-1], qx_i} - {nx_i[COORD_BITS-1], nx_i};
  assign dy   = {qy_i[COORD_BITS-1], qy_i} - {ny_i[COORD_BITS-1], ny_i};
  assign adx  = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign ady  = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
  assign ax_w = 32'(adx[COORD_BITS-1:0]);
  assign ay_w = 32'(ady[COORD_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // a magnitude of 2^16 or more squares above every squared radius
    s1_far_q <= (|ax_w[31:16]) | (|ay_w[31:16]);
    s1_idx_q <= in_idx_i;
    s1_ax_q  <= ax_w[15:0];
    s1_ay_q  <= ay_w[15:0];
    s2_far_q <= s1_far_q;
    s2_idx_q <= s1_idx_q;
    s2_sqx_q <= s1_ax_q * s1_ax_q;
    s2_sqy_q <= s1_ay_q * s1_ay_q;
    s3_far_q <= s2_far_q;
    s3_idx_q <= s2_idx_q;
    s3_dsq_q <= {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
  end

  assign res_o.valid = s3_valid_q;
  assign res_o.far   = s3_far_q;
  assign res_o.d_sq  = s3_dsq_q;
  assign res_idx_o   = s3_idx_q;
  assign busy_o      = s1_valid_q | s2_valid_q | s3_valid_q;

endmodule

`default_nettype wire

### tb/nearest_node_and_kill_query_unit_test.sv
// ----------------------------------------------------------------------------
// nearest_node_and_kill_query_unit_test
// Self-checking bench for the nearest node and kill query unit. Node loads
// and attractor queries go in through a bursty valid/ready driver. Results
// come out under a changing stall pattern. Each accepted query is predicted
// from a mirror of the node set and the radii, and each result is checked
// against it. Directed corner items come first, then random clustered
// load/query sequences under several radius settings.
// ----------------------------------------------------------------------------
module nearest_node_and_kill_query_unit_test;

  localparam int MAX_NODES   = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 16;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                on_valid_unused_guard;
  logic                in_valid = 1'b0;
  logic                in_ready;
  nnkq_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  nnkq_pkg::out_item_t out_item;
  logic                                 cfg_we = 1'b0;
  logic [nnkq_pkg::CFG_IDX_W-1:0]       cfg_index = nnkq_pkg::CFG_ATTRACT;
  logic [nnkq_pkg::RAD_W-1:0]           cfg_wdata = '0;

  // stimulus side
  nnkq_pkg::in_item_t pending_items[$];
  int                 load_xs[$];
  int                 load_ys[$];
  int                 burst_left = 0;
  int                 gap_left = 0;

  // mirror of the block
  logic signed [nnkq_pkg::FIELD_W-1:0] node_x[MAX_NODES];
  logic signed [nnkq_pkg::FIELD_W-1:0] node_y[MAX_NODES];
  int                                  node_total = 0;
  logic [nnkq_pkg::RAD_W-1:0]          attract_r = '0;
  logic [nnkq_pkg::RAD_W-1:0]          kill_r = '0;
  nnkq_pkg::out_item_t                 answers_due[$];
  nnkq_pkg::out_item_t                 want;

  int stall_mode = 0;
  int stall_span = 0;
  int cycle_count = 0;
  bit failed = 1'b0;

  nearest_node_and_kill_query_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_node_and_kill_query_unit_test failed");
      $finish;
    end
  end

  // sender: bursts of items with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall mode is redrawn after a random span
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_span <= $urandom_range(16, 96);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic track_item(input nnkq_pkg::in_item_t it);
    longint              qx, qy, dx, dy, d, best, kill_sq;
    nnkq_pkg::out_item_t res;
    if (it.op == nnkq_pkg::OP_LOAD) begin
      if (it.restart) node_total = 0;
      if (node_total < MAX_NODES) begin
        node_x[node_total] = it.px;
        node_y[node_total] = it.py;
        node_total++;
      end
    end else begin
      qx      = longint'($signed(it.px));
      qy      = longint'($signed(it.py));
      best    = longint'(attract_r) * longint'(attract_r);
      kill_sq = longint'(kill_r) * longint'(kill_r);
      res     = '0;
      for (int j = 0; j < node_total; j++) begin
        dx = qx - longint'(node_x[j]);
        dy = qy - longint'(node_y[j]);
        d  = dx * dx + dy * dy;
        if (d < best) begin
          best = d;
          res.nearest_index = nnkq_pkg::IDX_OUT_W'(j + 1);
        end
        if (d <= kill_sq) res.killed = 1'b1;
      end
      answers_due.insert(answers_due.size(), res);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) track_item(in_item);
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, nearest_index %0d killed %0d", $time,
                   out_item.nearest_index, out_item.killed);
          failed = 1'b1;
        end else begin
          want = answers_due.pop_front();
          if (out_item.nearest_index !== want.nearest_index) begin
            $display("%0t: nearest_index expected %0d actual %0d", $time,
                     want.nearest_index, out_item.nearest_index);
            failed = 1'b1;
          end
          if (out_item.killed !== want.killed) begin
            $display("%0t: killed expected %0d actual %0d", $time,
                     want.killed, out_item.killed);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic void add_item(input logic op, input int x, input int y,
                                   input logic restart);
    nnkq_pkg::in_item_t it;
    it.op      = op;
    it.px      = x[nnkq_pkg::FIELD_W-1:0];
    it.py      = y[nnkq_pkg::FIELD_W-1:0];
    it.restart = restart;
    pending_items.insert(pending_items.size(), it);
    if (op == nnkq_pkg::OP_LOAD) begin
      if (restart) begin
        load_xs.delete();
        load_ys.delete();
      end
      load_xs.insert(load_xs.size(), x);
      load_ys.insert(load_ys.size(), y);
    end
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || answers_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_radii(input logic [nnkq_pkg::RAD_W-1:0] attract,
                           input logic [nnkq_pkg::RAD_W-1:0] kill);
    wait_idle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= nnkq_pkg::CFG_ATTRACT;
    cfg_wdata <= attract;
    @(posedge clk_i);
    cfg_index <= nnkq_pkg::CFG_KILL;
    cfg_wdata <= kill;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    attract_r = attract;
    kill_r    = kill;
  endtask

  function automatic logic [nnkq_pkg::RAD_W-1:0] pick_radius();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return nnkq_pkg::RAD_W'($urandom_range(1, 64));
      3: return nnkq_pkg::RAD_W'($urandom_range(64, 2048));
      default: return nnkq_pkg::RAD_W'($urandom);
    endcase
  endfunction

  function automatic int spread_off(input int sp);
    int o;
    o = $urandom_range(0, 2 * sp);
    return o - sp;
  endfunction

  // one clustered load sequence followed by queries around the cluster
  function automatic int add_cluster();
    int cx, cy, sp, n_ld, n_q, k, count;
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 2))
      0: sp = 16;
      1: sp = 256;
      default: sp = 4096;
    endcase
    n_ld = $urandom_range(1, 24);
    n_q  = $urandom_range(1, 5);
    add_item(nnkq_pkg::OP_LOAD, cx + spread_off(sp), cy + spread_off(sp),
             $urandom_range(0, 3) != 0);
    for (int i = 1; i < n_ld; i++)
      add_item(nnkq_pkg::OP_LOAD, cx + spread_off(sp), cy + spread_off(sp), 1'b0);
    for (int i = 0; i < n_q; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, load_xs.size() - 1);
        add_item(nnkq_pkg::OP_QUERY, load_xs[k], load_ys[k], $urandom_range(0, 1) == 1);
      end else begin
        add_item(nnkq_pkg::OP_QUERY, cx + spread_off(2 * sp), cy + spread_off(2 * sp),
                 $urandom_range(0, 1) == 1);
      end
    end
    count = n_ld + n_q;
    return count;
  endfunction

  initial begin : stimulus
    int sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes of coordinates and radii, ties, empty set
    set_radii('1, '1);
    add_item(nnkq_pkg::OP_QUERY, 0, 0, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, -32768, -32768, 1'b1);
    add_item(nnkq_pkg::OP_LOAD, 32767, 32767, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, 32767, -32768, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, -32768, 32767, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, 0, 0, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, 0, 0, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 0, 0, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 32767, -32768, 1'b1);
    add_item(nnkq_pkg::OP_QUERY, 16, -16, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 32767, 0, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, 100, 100, 1'b1);
    add_item(nnkq_pkg::OP_QUERY, -32768, -32768, 1'b0);

    // zero radii: no attraction, kill only on an exact hit
    set_radii('0, '0);
    add_item(nnkq_pkg::OP_QUERY, 100, 100, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 101, 100, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, 100, 100, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 100, 100, 1'b1);

    // boundaries of strict and inclusive compares
    set_radii(16'd16, 16'd15);
    add_item(nnkq_pkg::OP_LOAD, 0, 0, 1'b1);
    add_item(nnkq_pkg::OP_LOAD, 16, 0, 1'b0);
    add_item(nnkq_pkg::OP_LOAD, 0, -15, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 16, 16, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 0, 1, 1'b0);
    add_item(nnkq_pkg::OP_QUERY, 8, -8, 1'b0);

    // restart down to a single node
    set_radii('1, pick_radius());
    add_item(nnkq_pkg::OP_LOAD, 1234, -4321, 1'b1);
    add_item(nnkq_pkg::OP_QUERY, 1234, -4300, 1'b0);

    // random phases under several radius settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_radii('1, '0);
        1: set_radii('0, '1);
        default: set_radii(pick_radius(), pick_radius());
      endcase
      sent = 0;
      while (sent < 48) begin
        if ($urandom_range(0, 6) == 0) begin
          add_item($urandom_range(0, 1) == 1, $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 3) == 0);
          sent++;
        end else begin
          sent += add_cluster();
        end
      end
    end

    wait_idle();
    if (!failed) begin
      $display("nearest_node_and_kill_query_unit_test passed");
    end else begin
      $display("nearest_node_and_kill_query_unit_test failed");
    end
    $finish;
  end

endmodule
